@@ src/tgf_pkg.sv @@
// Package for the track gap linear fill core: field widths, command kinds
// and the command item passed from the front end to the back end.
// No dependencies.
`default_nettype none
package tgf_pkg;

  localparam int LAT_W = 38;
  localparam int LON_W = 39;
  localparam int ALT_W = 28;
  localparam int TAG_W = 32;
  localparam int CNT_W = 6;
  localparam int N_W   = 7;
  localparam int DIV_W = 40;
  localparam int DIF_W = 41;
  localparam int DCNT_W = 6;

  typedef enum logic [3:0] {
    CMD_STORE = 4'b0001,
    CMD_START = 4'b0010,
    CMD_FLUSH = 4'b0100,
    CMD_FILL  = 4'b1000
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic signed [ALT_W-1:0] alt;
    logic [TAG_W-1:0]        tag;
    logic                    tend;
    logic                    missing;
    logic [CNT_W-1:0]        count;
  } cmd_t;

endpackage
`default_nettype wire

@@ src/tgf_if.sv @@
// Stream interfaces for sample items in and result items out.
// Depends on tgf_pkg for the field widths.
`default_nettype none
interface tgf_in_if import tgf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] lat_in;
  logic signed [LON_W-1:0] lon_in;
  logic signed [ALT_W-1:0] alt_in;
  logic [TAG_W-1:0]        tag_in;
  logic                    track_end_in;
  modport source (output valid, lat_in, lon_in, alt_in, tag_in, track_end_in,
                  input ready);
  modport sink (input valid, lat_in, lon_in, alt_in, tag_in, track_end_in,
                output ready);
endinterface

interface tgf_out_if import tgf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] lat_out;
  logic signed [LON_W-1:0] lon_out;
  logic signed [ALT_W-1:0] alt_out;
  logic [TAG_W-1:0]        tag_out;
  logic                    was_filled;
  logic                    gap_unfilled;
  logic                    track_end_out;
  logic                    burst_end;
  modport source (output valid, lat_out, lon_out, alt_out, tag_out, was_filled,
                  gap_unfilled, track_end_out, burst_end, input ready);
  modport sink (input valid, lat_out, lon_out, alt_out, tag_out, was_filled,
                gap_unfilled, track_end_out, burst_end, output ready);
endinterface
`default_nettype wire

@@ src/tgf_front.sv @@
// Front end: accepts sample items, tracks run state and classifies each
// item into a command. Depends on tgf_pkg and tgf_if.
`default_nettype none
module tgf_front import tgf_pkg::*; #(
  parameter int MAX_GAP = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  tgf_in_if.sink    samples,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  wire logic cmd_ready
);

  logic             at_track_start;
  logic             run_broken;
  logic [CNT_W-1:0] gap_count;
  logic             missing;
  logic             accept;

  assign missing   = (samples.lat_in == '0) && (samples.lon_in == '0);
  assign cmd_valid = samples.valid;
  assign samples.ready = cmd_ready;
  assign accept    = samples.valid && cmd_ready;

  always_comb begin
    cmd.lat     = samples.lat_in;
    cmd.lon     = samples.lon_in;
    cmd.alt     = samples.alt_in;
    cmd.tag     = samples.tag_in;
    cmd.tend    = samples.track_end_in;
    cmd.missing = missing;
    cmd.count   = gap_count;
    if (at_track_start) begin
      cmd.kind = CMD_START;
    end else if (missing) begin
      if (samples.track_end_in || run_broken || gap_count >= CNT_W'(MAX_GAP)) begin
        cmd.kind = CMD_FLUSH;
      end else begin
        cmd.kind = CMD_STORE;
      end
    end else begin
      cmd.kind = CMD_FILL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_track_start <= 1'b1;
      run_broken     <= 1'b0;
      gap_count      <= '0;
    end else if (accept) begin
      case (cmd.kind)
        CMD_START: begin
          gap_count      <= '0;
          run_broken     <= 1'b0;
          at_track_start <= samples.track_end_in;
        end
        CMD_FLUSH: begin
          gap_count  <= '0;
          run_broken <= !samples.track_end_in;
        end
        CMD_STORE: begin
          gap_count <= gap_count + 1'b1;
        end
        default: begin
          gap_count  <= '0;
          run_broken <= 1'b0;
        end
      endcase
      if (samples.track_end_in) begin
        at_track_start <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/tgf_cmd_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on tgf_pkg.
`default_nettype none
module tgf_cmd_queue import tgf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t wr_data,
  input  wire logic wr_valid,
  output logic      wr_ready,
  output cmd_t      rd_data,
  output logic      rd_valid,
  input  wire logic rd_ready
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/tgf_back.sv @@
// Back end: holds the anchor and gap buffer, runs the per-coordinate dividers
// and drains filled or unfilled runs into the output register.
// Depends on tgf_pkg and tgf_if.
`default_nettype none
module tgf_back import tgf_pkg::*; #(
  parameter int MAX_GAP = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd_in,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  tgf_out_if.source results
);

  localparam int AW = (MAX_GAP > 1) ? $clog2(MAX_GAP) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_READ = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_LAST = 5'b10000
  } state_t;

  state_t                  state;
  cmd_t                    cmd;
  logic signed [LAT_W-1:0] anchor_lat;
  logic signed [LON_W-1:0] anchor_lon;
  logic signed [ALT_W-1:0] anchor_alt;
  logic [TAG_W-1:0]        gap_tags [MAX_GAP];
  logic [ALT_W-1:0]        gap_alts [MAX_GAP];
  logic [TAG_W-1:0]        rd_tag;
  logic [ALT_W-1:0]        rd_alt;
  logic [CNT_W-1:0]        k;
  logic [DCNT_W-1:0]       div_cnt;
  logic [N_W-1:0]          n;
  logic [DIV_W-1:0]        dvd [3];
  logic [N_W-1:0]          rem [3];
  logic [DIV_W-1:0]        q_acc [3];
  logic [N_W-1:0]          r_acc [3];
  logic [2:0]              neg;
  logic signed [DIF_W-1:0] diff [3];
  logic signed [DIF_W-1:0] anc_x [3];
  logic signed [DIF_W-1:0] fill_v [3];
  logic [N_W:0]            rem_s [3];
  logic [N_W:0]            r_sum [3];
  logic                    slot_free;
  logic                    out_valid;
  logic                    out_load;

  assign n         = N_W'(cmd.count) + 1'b1;
  assign slot_free = !out_valid || results.ready;
  assign out_load  = ((state == ST_EMIT) || (state == ST_LAST)) && slot_free;
  assign results.valid = out_valid;
  assign cmd_ready = (state == ST_IDLE);

  always_comb begin
    anc_x[0] = DIF_W'(anchor_lat);
    anc_x[1] = DIF_W'(anchor_lon);
    anc_x[2] = DIF_W'(anchor_alt);
    diff[0]  = DIF_W'(cmd_in.lat) - DIF_W'(anchor_lat);
    diff[1]  = DIF_W'(cmd_in.lon) - DIF_W'(anchor_lon);
    diff[2]  = DIF_W'(cmd_in.alt) - DIF_W'(anchor_alt);
    for (int i = 0; i < 3; i++) begin
      rem_s[i] = {rem[i], dvd[i][DIV_W-1]};
      r_sum[i] = {1'b0, r_acc[i]} + {1'b0, rem[i]};
      fill_v[i] = neg[i] ? anc_x[i] - DIF_W'(q_acc[i]) : anc_x[i] + DIF_W'(q_acc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid && cmd_in.kind == CMD_STORE) begin
      gap_tags[cmd_in.count[AW-1:0]] <= cmd_in.tag;
      gap_alts[cmd_in.count[AW-1:0]] <= cmd_in.alt;
    end
    rd_tag <= gap_tags[k[AW-1:0]];
    rd_alt <= gap_alts[k[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      anchor_lat <= '0;
      anchor_lon <= '0;
      anchor_alt <= '0;
      k          <= '0;
      div_cnt    <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd_in.kind != CMD_STORE) begin
            cmd <= cmd_in;
            k   <= '0;
            for (int i = 0; i < 3; i++) begin
              neg[i]   <= diff[i][DIF_W-1];
              dvd[i]   <= diff[i][DIF_W-1] ? DIV_W'(-diff[i]) : DIV_W'(diff[i]);
              rem[i]   <= '0;
              q_acc[i] <= '0;
              r_acc[i] <= '0;
            end
            div_cnt <= '0;
            if (cmd_in.count == '0) begin
              state <= ST_LAST;
            end else if (cmd_in.kind == CMD_FILL) begin
              state <= ST_DIV;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (rem_s[i] >= {1'b0, n}) begin
              rem[i] <= N_W'(rem_s[i] - {1'b0, n});
              dvd[i] <= {dvd[i][DIV_W-2:0], 1'b1};
            end else begin
              rem[i] <= N_W'(rem_s[i]);
              dvd[i] <= {dvd[i][DIV_W-2:0], 1'b0};
            end
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCNT_W'(DIV_W - 1)) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          for (int i = 0; i < 3; i++) begin
            if (r_sum[i] >= {1'b0, n}) begin
              r_acc[i] <= N_W'(r_sum[i] - {1'b0, n});
              q_acc[i] <= q_acc[i] + dvd[i] + 1'b1;
            end else begin
              r_acc[i] <= N_W'(r_sum[i]);
              q_acc[i] <= q_acc[i] + dvd[i];
            end
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            results.tag_out       <= rd_tag;
            results.track_end_out <= 1'b0;
            results.burst_end     <= 1'b0;
            if (cmd.kind == CMD_FILL) begin
              results.lat_out      <= LAT_W'(fill_v[0]);
              results.lon_out      <= LON_W'(fill_v[1]);
              results.alt_out      <= ALT_W'(fill_v[2]);
              results.was_filled   <= 1'b1;
              results.gap_unfilled <= 1'b0;
            end else begin
              results.lat_out      <= '0;
              results.lon_out      <= '0;
              results.alt_out      <= rd_alt;
              results.was_filled   <= 1'b0;
              results.gap_unfilled <= 1'b1;
            end
            k <= k + 1'b1;
            if (k + 1'b1 == cmd.count) begin
              state <= ST_LAST;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_LAST: begin
          if (slot_free) begin
            results.tag_out       <= cmd.tag;
            results.alt_out       <= cmd.alt;
            results.was_filled    <= 1'b0;
            results.track_end_out <= cmd.tend;
            results.burst_end     <= 1'b1;
            if (cmd.kind == CMD_FLUSH) begin
              results.lat_out      <= '0;
              results.lon_out      <= '0;
              results.gap_unfilled <= 1'b1;
            end else begin
              results.lat_out      <= cmd.lat;
              results.lon_out      <= cmd.lon;
              results.gap_unfilled <= (cmd.kind == CMD_START) && cmd.missing;
              anchor_lat           <= cmd.lat;
              anchor_lon           <= cmd.lon;
              anchor_alt           <= cmd.alt;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_div_only_fill: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cmd.kind == CMD_FILL)
    else $error("divider running for a command that is not a fill");

  a_emit_in_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> k < cmd.count)
    else $error("drain index beyond the buffered run");

  a_last_marks_burst: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LAST && slot_free) |=> (out_valid && results.burst_end))
    else $error("final result of a command not marked as burst end");

endmodule
`default_nettype wire

@@ src/track_gap_linear_fill_core.sv @@
// Top level of the track gap linear fill core: front end, command queue
// and back end. Depends on tgf_pkg, tgf_if and the three submodules.
//
//   Channel   Dir  Handshake     Payload
//   samples   in   valid/ready   lat_in lon_in alt_in tag_in track_end_in
//   results   out  valid/ready   lat_out lon_out alt_out tag_out was_filled
//                                gap_unfilled track_end_out burst_end
//
// A buffered sample is stored in the gap buffer while the back end idles;
// a sample that emits results steps through READ and EMIT per drained
// entry, then LAST. A fill of a run first runs the bit-serial dividers in
// DIV, one per coordinate. Reset is synchronous and needs no clearing pass.
// The two-entry queue lets the front accept items while results stall.
`default_nettype none
module track_gap_linear_fill_core import tgf_pkg::*; #(
  parameter int MAX_GAP = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  tgf_in_if.sink    samples,
  tgf_out_if.source results
);

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  tgf_front #(.MAX_GAP(MAX_GAP)) u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  tgf_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (front_cmd),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_data  (back_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  tgf_back #(.MAX_GAP(MAX_GAP)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_in    (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .results   (results)
  );

endmodule
`default_nettype wire
